[rtl/core/refcounted_page_allocator_top_defines.svh]
`ifndef REFCOUNTED_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RPA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/rpa_pkg.sv]
package rpa_pkg;

    localparam int NUM_PAGES  = 16384;
    localparam int COUNT_BITS = 8;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);
    localparam int LIMIT_W    = 15;

    typedef enum logic [2:0] {
        ACT_ALLOC   = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_SEED    = 3'd2,
        ACT_INC     = 3'd3,
        ACT_DEC     = 3'd4,
        ACT_QUERY   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    typedef enum logic {
        REG_LOWEST_PAGE = 1'b0,
        REG_PAGE_LIMIT  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [PAGE_W-1:0] page;
    } in_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [PAGE_W-1:0]     page_out;
        logic [COUNT_BITS-1:0] ref_count;
        logic [DEPTH_W-1:0]    free_pages;
    } out_t;

    typedef struct packed {
        logic                  re;
        logic [PAGE_W-1:0]     raddr;
        logic                  we;
        logic [PAGE_W-1:0]     waddr;
        logic [COUNT_BITS-1:0] wdata;
    } cnt_req_t;

    typedef struct packed {
        logic              re;
        logic [PAGE_W-1:0] raddr;
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [PAGE_W-1:0] wdata;
    } stk_req_t;

endpackage

[rtl/core/rpa_stack_mem.sv]
module rpa_stack_mem (
    input  logic                      aclk,
    input  rpa_pkg::stk_req_t         req,
    output logic [rpa_pkg::PAGE_W-1:0] rdata
);
    import rpa_pkg::*;

    logic [PAGE_W-1:0] mem [NUM_PAGES];
    logic [PAGE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rpa_count_mem.sv]
module rpa_count_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rpa_pkg::cnt_req_t             req,
    output logic [rpa_pkg::COUNT_BITS-1:0] rdata,
    output logic                          busy
);
    import rpa_pkg::*;

    logic [COUNT_BITS-1:0] mem [NUM_PAGES];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [PAGE_W-1:0]     clr_idx_reg;
    logic                  clearing_reg;

    // After reset every entry is swept to zero, one per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            clearing_reg <= 1'b1;
        end else if (clearing_reg) begin
            clr_idx_reg <= clr_idx_reg + PAGE_W'(1);
            if (clr_idx_reg == PAGE_W'(NUM_PAGES - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

[rtl/core/rpa_ctrl.sv]
`include "refcounted_page_allocator_top_defines.svh"

module rpa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rpa_pkg::PAGE_W-1:0]    lowest_page,
    input  logic [rpa_pkg::LIMIT_W-1:0]   page_limit,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rpa_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rpa_pkg::out_t                 m_data,
    input  logic                          clr_busy,
    output rpa_pkg::cnt_req_t             cnt_req,
    input  logic [rpa_pkg::COUNT_BITS-1:0] cnt_rdata,
    output rpa_pkg::stk_req_t             stk_req,
    input  logic [rpa_pkg::PAGE_W-1:0]    stk_rdata
);
    import rpa_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    state_t                state_reg;
    in_t                   item_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    logic [DEPTH_W-1:0]    depth_next;
    logic                  m_valid_reg;
    out_t                  m_data_reg;
    out_t                  result_next;
    logic                  accept;
    logic                  in_range;
    logic [COUNT_BITS-1:0] rel_cnt;

    assign s_ready = (state_reg == S_IDLE) && !clr_busy && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign in_range = (item_reg.page >= lowest_page)
                   && ({1'b0, item_reg.page} < page_limit);

    always_comb begin
        rel_cnt = (item_reg.action == ACT_SEED) ? '0 : cnt_rdata;
        if (rel_cnt != '0) begin
            rel_cnt = rel_cnt - COUNT_BITS'(1);
        end
    end

    always_comb begin
        // Both memories are read on the accepting edge; the data is there in S_EXEC.
        cnt_req.re    = accept;
        cnt_req.raddr = s_data.page;
        stk_req.re    = accept;
        stk_req.raddr = depth_reg[PAGE_W-1:0] - PAGE_W'(1);
        result_next.status   = ST_OK;
        result_next.page_out = item_reg.page;
        result_next.ref_count = '0;
        depth_next    = depth_reg;
        cnt_req.we    = 1'b0;
        cnt_req.waddr = item_reg.page;
        cnt_req.wdata = '0;
        stk_req.we    = 1'b0;
        stk_req.waddr = depth_reg[PAGE_W-1:0];
        stk_req.wdata = item_reg.page;
        case (item_reg.action)
            ACT_ALLOC: begin
                if (depth_reg == '0) begin
                    result_next.status = ST_EMPTY;
                end else begin
                    depth_next            = depth_reg - DEPTH_W'(1);
                    result_next.page_out  = stk_rdata;
                    result_next.ref_count = COUNT_BITS'(1);
                    cnt_req.we            = 1'b1;
                    cnt_req.waddr         = stk_rdata;
                    cnt_req.wdata         = COUNT_BITS'(1);
                end
            end
            ACT_RELEASE, ACT_SEED: begin
                if (!in_range) begin
                    result_next.status = ST_RANGE;
                end else begin
                    cnt_req.we            = 1'b1;
                    cnt_req.wdata         = rel_cnt;
                    result_next.ref_count = rel_cnt;
                    if (rel_cnt == '0) begin
                        if (depth_reg == DEPTH_W'(NUM_PAGES)) begin
                            result_next.status = ST_FULL;
                        end else begin
                            stk_req.we = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end
                end
            end
            ACT_INC: begin
                if (cnt_rdata == COUNT_MAX) begin
                    result_next.status    = ST_SAT;
                    result_next.ref_count = cnt_rdata;
                end else begin
                    cnt_req.we            = 1'b1;
                    cnt_req.wdata         = cnt_rdata + COUNT_BITS'(1);
                    result_next.ref_count = cnt_rdata + COUNT_BITS'(1);
                end
            end
            ACT_DEC: begin
                if (cnt_rdata == '0) begin
                    result_next.status = ST_SAT;
                end else begin
                    cnt_req.we            = 1'b1;
                    cnt_req.wdata         = cnt_rdata - COUNT_BITS'(1);
                    result_next.ref_count = cnt_rdata - COUNT_BITS'(1);
                end
            end
            ACT_QUERY: begin
                result_next.ref_count = cnt_rdata;
            end
            default: begin
                result_next.status = ST_OK;
            end
        endcase
        if (state_reg != S_EXEC) begin
            cnt_req.we = 1'b0;
            stk_req.we = 1'b0;
            depth_next = depth_reg;
        end
        result_next.free_pages = depth_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        item_reg  <= s_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    m_data_reg  <= result_next;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RPA_ASSERT_IMP(a_depth_bound, aclk, aresetn, 1'b1, depth_reg <= DEPTH_W'(NUM_PAGES))
    `RPA_ASSERT_IMP(a_no_accept_clear, aclk, aresetn, clr_busy, !s_ready)
    `RPA_ASSERT_NEXT(a_accept_exec, aclk, aresetn, accept, state_reg == S_EXEC)
    `RPA_ASSERT_NEXT(a_exec_result, aclk, aresetn, state_reg == S_EXEC, m_valid_reg)

endmodule

[rtl/core/refcounted_page_allocator_top.sv]
// Channel    | Direction | Handshake          | Payload
// s_ (items) | in        | s_valid / s_ready  | s_data  : action, page
// m_ (results)| out      | m_valid / m_ready  | m_data  : status, page_out, ref_count, free_pages
// APB config | in        | psel/penable/pready | lowest_page at 0x0, page_limit at 0x4
//
// For each item, the accepting edge reads the count and stack memories,
// and the next edge writes them back and loads the result register.
// The memory reads are registered; one item is worked on at a time.
// After reset a clearing pass zeroes all 16384 count memory entries; s_ready stays low
// during the pass, while configuration writes are taken as usual.
// A stalled result beat holds s_ready low until it is taken.
module refcounted_page_allocator_top (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  rpa_pkg::in_t             s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rpa_pkg::out_t            m_data
);
    import rpa_pkg::*;

    logic [PAGE_W-1:0]     lowest_page_reg;
    logic [LIMIT_W-1:0]    page_limit_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;
    cnt_req_t              cnt_req;
    stk_req_t              stk_req;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [PAGE_W-1:0]     stk_rdata;
    logic                  clr_busy;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_page_reg <= '0;
            page_limit_reg  <= LIMIT_W'(NUM_PAGES);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LOWEST_PAGE: lowest_page_reg <= pwdata[PAGE_W-1:0];
                REG_PAGE_LIMIT:  page_limit_reg  <= pwdata[LIMIT_W-1:0];
                default: begin
                    lowest_page_reg <= lowest_page_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LOWEST_PAGE: prdata = 32'(lowest_page_reg);
            REG_PAGE_LIMIT:  prdata = 32'(page_limit_reg);
            default:         prdata = '0;
        endcase
    end

    rpa_count_mem u_count_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cnt_req),
        .rdata   (cnt_rdata),
        .busy    (clr_busy)
    );

    rpa_stack_mem u_stack_mem (
        .aclk  (aclk),
        .req   (stk_req),
        .rdata (stk_rdata)
    );

    rpa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lowest_page (lowest_page_reg),
        .page_limit  (page_limit_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .clr_busy    (clr_busy),
        .cnt_req     (cnt_req),
        .cnt_rdata   (cnt_rdata),
        .stk_req     (stk_req),
        .stk_rdata   (stk_rdata)
    );

endmodule
